// File: sv/rmj_pkg.sv
// Shared types, constants and the output clamp for the radar measurement Jacobian.
package rmj_pkg;

    localparam int QW         = 32;              // quotient / root width
    localparam int PIPE_STEPS = 2;               // iterations per register stage
    localparam int PIPE_NSTG  = QW / PIPE_STEPS;
    localparam int PIPE_LAT   = PIPE_NSTG + 1;   // entry register plus iteration stages

    localparam logic [15:0] THRESH_RESET = 16'd7;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } rmj_track_t;

    typedef struct packed {
        logic signed [31:0] d_range_d_x;
        logic signed [31:0] d_range_d_y;
        logic signed [31:0] d_bearing_d_x;
        logic signed [31:0] d_bearing_d_y;
        logic signed [31:0] d_rate_d_x;
        logic signed [31:0] d_rate_d_y;
        logic               origin_flag;
        logic               saturated_flag;
    } rmj_jac_t;

    typedef struct packed {
        logic x_neg;
        logic y_neg;
        logic y_pos;
        logic c_neg;
    } rmj_sign_t;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } rmj_clamp_t;

    // Apply sign to an unsigned quotient and clamp to the 32-bit signed range.
    function automatic rmj_clamp_t rmj_clamp(input logic neg, input logic [31:0] q,
                                             input logic ovf);
        rmj_clamp_t  res;
        logic [31:0] lim;
        logic [31:0] mag;
        lim     = neg ? 32'h8000_0000 : 32'h7fff_ffff;
        res.sat = ovf || (q > lim);
        mag     = res.sat ? lim : q;
        res.val = neg ? (32'd0 - mag) : mag;
        return res;
    endfunction

endpackage

// File: sv/rmj_sqrt.sv
// Pipelined 64-bit integer square root, PIPE_STEPS bit-pair iterations per stage.
module rmj_sqrt
    import rmj_pkg::*;
(
    input  logic        clk,
    input  logic [63:0] s,
    output logic [31:0] r
);

    logic [63:0] op_reg  [PIPE_NSTG+1];
    logic [63:0] res_reg [PIPE_NSTG+1];

    always_ff @(posedge clk)
    begin
        op_reg[0]  <= s;
        res_reg[0] <= '0;
    end

    for (genvar g = 0; g < PIPE_NSTG; g++) begin : g_stg
        logic [63:0] op_v;
        logic [63:0] res_v;
        logic [63:0] one_v;

        always_comb
        begin
            op_v  = op_reg[g];
            res_v = res_reg[g];
            one_v = '0;
            for (int k = 0; k < PIPE_STEPS; k++) begin
                one_v = 64'd1 << (62 - 2 * (g * PIPE_STEPS + k));
                if (op_v >= res_v + one_v) begin
                    op_v  = op_v - (res_v + one_v);
                    res_v = (res_v >> 1) + one_v;
                end else begin
                    res_v = res_v >> 1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            op_reg[g+1]  <= op_v;
            res_reg[g+1] <= res_v;
        end
    end

    assign r = res_reg[PIPE_NSTG][31:0];

endmodule

// File: sv/rmj_div.sv
// Pipelined restoring divider: 32-bit quotient plus overflow when it needs more bits.
module rmj_div
    import rmj_pkg::*;
#(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32
)
(
    input  logic             clk,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QW-1:0]    quo,
    output logic             ovf
);

    logic [DEN_W-1:0] rem_reg [PIPE_NSTG+1];
    logic [DEN_W-1:0] den_reg [PIPE_NSTG+1];
    logic [QW-1:0]    lo_reg  [PIPE_NSTG+1];
    logic [QW-1:0]    q_reg   [PIPE_NSTG+1];
    logic             ovf_reg [PIPE_NSTG+1];

    logic [DEN_W-1:0] num_hi;

    // quotient >= 2^32 exactly when the upper part already reaches the divisor
    assign num_hi = DEN_W'(num[NUM_W-1:QW]);

    always_ff @(posedge clk)
    begin
        ovf_reg[0] <= (num_hi >= den);
        rem_reg[0] <= num_hi;
        den_reg[0] <= den;
        lo_reg[0]  <= num[QW-1:0];
        q_reg[0]   <= '0;
    end

    for (genvar g = 0; g < PIPE_NSTG; g++) begin : g_stg
        logic [DEN_W-1:0] rem_v;
        logic [DEN_W:0]   rem_w;
        logic [QW-1:0]    lo_v;
        logic [QW-1:0]    q_v;

        always_comb
        begin
            rem_v = rem_reg[g];
            lo_v  = lo_reg[g];
            q_v   = q_reg[g];
            rem_w = '0;
            for (int k = 0; k < PIPE_STEPS; k++) begin
                rem_w = {rem_v, lo_v[QW-1]};
                lo_v  = lo_v << 1;
                if (rem_w >= {1'b0, den_reg[g]}) begin
                    rem_w = rem_w - {1'b0, den_reg[g]};
                    q_v   = {q_v[QW-2:0], 1'b1};
                end else begin
                    q_v   = {q_v[QW-2:0], 1'b0};
                end
                rem_v = rem_w[DEN_W-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[g+1] <= rem_v;
            den_reg[g+1] <= den_reg[g];
            lo_reg[g+1]  <= lo_v;
            q_reg[g+1]   <= q_v;
            ovf_reg[g+1] <= ovf_reg[g];
        end
    end

    assign quo = q_reg[PIPE_NSTG];
    assign ovf = ovf_reg[PIPE_NSTG];

endmodule

// File: sv/radar_measurement_jacobian.sv
// Top level: fixed-point radar measurement Jacobian, fully pipelined.
//
//  channel    | signals                        | transaction when
//  -----------+--------------------------------+-------------------------------
//  track      | start, busy, track             | start && !busy at clk rise
//  jacobian   | done, jacobian                 | every cycle done is high
//  config     | cfg_valid, cfg_ready, cfg_data | cfg_valid && cfg_ready
//
//  One track state per cycle, sustained. The pipeline runs through three front
//  stages (abs, 32x32 products, sums), the square root array (PIPE_LAT), two
//  partial-product stages, the divider arrays (PIPE_LAT) and the output
//  register. The root and divider arrays retire two bits per stage.
//  Reset clears all valid bits and loads the threshold with 7. busy stays low
//  and cfg_ready stays high; the result side has no backpressure.
module radar_measurement_jacobian
    import rmj_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  rmj_track_t  track,
    output logic        done,
    output rmj_jac_t    jacobian,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int TOTAL_LAT = 3 + PIPE_LAT + 2 + PIPE_LAT + 1;
    localparam int N0_W = 32 + FRAC_BITS;
    localparam int N2_W = 32 + 2 * FRAC_BITS;
    localparam int N4_W = 95 + FRAC_BITS;

    typedef struct packed {
        rmj_sign_t   sign;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [63:0] cmag;
        logic [63:0] s;
    } side_t;

    typedef struct packed {
        rmj_sign_t sign;
        logic      origin;
    } tag_t;

    logic accept;
    logic [15:0] thr_reg;

    // stage 1: magnitudes
    logic               v1_reg;
    logic signed [31:0] x1_reg, y1_reg, vx1_reg, vy1_reg;
    logic [31:0]        ax1_reg, ay1_reg;
    // stage 2: products
    logic               v2_reg;
    logic [63:0]        sqx2_reg, sqy2_reg;
    logic signed [63:0] p1_2_reg, p2_2_reg;
    logic [31:0]        ax2_reg, ay2_reg;
    rmj_sign_t          sg2_reg;
    // stage 3: range squared and cross term
    logic               v3_reg;
    side_t              sd3_reg;
    logic [64:0]        diff3;
    // root array side line
    logic [PIPE_LAT-1:0] sq_vld_reg;
    side_t               sq_side_reg [PIPE_LAT];
    logic [31:0]         root;
    side_t               sq_o;
    // M1: partial products
    logic        vm1_reg;
    tag_t        tm1_reg;
    logic [31:0] rm1_reg, axm1_reg, aym1_reg;
    logic [63:0] sm1_reg;
    logic [63:0] pa_lo_reg, pa_hi_reg, pb_lo_reg, pb_hi_reg, ps_lo_reg, ps_hi_reg;
    // M2: wide sums
    logic        vm2_reg;
    tag_t        tm2_reg;
    logic [31:0] rm2_reg, axm2_reg, aym2_reg;
    logic [63:0] sm2_reg;
    logic [95:0] aycm_reg, axcm_reg, sr_reg;
    // divider side line
    logic [PIPE_LAT-1:0] dv_vld_reg;
    tag_t                dv_tag_reg [PIPE_LAT];
    tag_t                dv_o;
    logic [31:0]         q0, q1, q2, q3, q4, q5;
    logic                o0, o1, o2, o3, o4, o5;
    rmj_clamp_t          c0, c1, c2, c3, c4, c5;
    // output
    logic     done_reg;
    rmj_jac_t jac_reg;
    rmj_jac_t jac_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            thr_reg <= THRESH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            thr_reg <= cfg_data;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            sq_vld_reg <= '0;
            vm1_reg    <= 1'b0;
            vm2_reg    <= 1'b0;
            dv_vld_reg <= '0;
            done_reg   <= 1'b0;
        end else begin
            v1_reg     <= accept;
            v2_reg     <= v1_reg;
            v3_reg     <= v2_reg;
            sq_vld_reg <= {sq_vld_reg[PIPE_LAT-2:0], v3_reg};
            vm1_reg    <= sq_vld_reg[PIPE_LAT-1];
            vm2_reg    <= vm1_reg;
            dv_vld_reg <= {dv_vld_reg[PIPE_LAT-2:0], vm2_reg};
            done_reg   <= dv_vld_reg[PIPE_LAT-1];
        end
    end

    // front end
    always_ff @(posedge clk)
    begin
        x1_reg  <= track.pos_x;
        y1_reg  <= track.pos_y;
        vx1_reg <= track.vel_x;
        vy1_reg <= track.vel_y;
        ax1_reg <= track.pos_x[31] ? 32'd0 - track.pos_x : track.pos_x;
        ay1_reg <= track.pos_y[31] ? 32'd0 - track.pos_y : track.pos_y;

        sqx2_reg      <= ax1_reg * ax1_reg;
        sqy2_reg      <= ay1_reg * ay1_reg;
        p1_2_reg      <= vx1_reg * y1_reg;
        p2_2_reg      <= vy1_reg * x1_reg;
        ax2_reg       <= ax1_reg;
        ay2_reg       <= ay1_reg;
        sg2_reg.x_neg <= x1_reg[31];
        sg2_reg.y_neg <= y1_reg[31];
        sg2_reg.y_pos <= !y1_reg[31] && (y1_reg != 32'sd0);
        sg2_reg.c_neg <= 1'b0;

        sd3_reg.sign.x_neg <= sg2_reg.x_neg;
        sd3_reg.sign.y_neg <= sg2_reg.y_neg;
        sd3_reg.sign.y_pos <= sg2_reg.y_pos;
        sd3_reg.sign.c_neg <= diff3[64];
        sd3_reg.ax         <= ax2_reg;
        sd3_reg.ay         <= ay2_reg;
        sd3_reg.cmag       <= diff3[64] ? 64'(65'd0 - diff3) : diff3[63:0];
        sd3_reg.s          <= sqx2_reg + sqy2_reg;
    end

    // c = vx*y - vy*x, kept as sign and magnitude
    assign diff3 = {p1_2_reg[63], p1_2_reg} - {p2_2_reg[63], p2_2_reg};

    rmj_sqrt u_sqrt (
        .clk (clk),
        .s   (sd3_reg.s),
        .r   (root)
    );

    always_ff @(posedge clk)
    begin
        sq_side_reg[0] <= sd3_reg;
        for (int i = 1; i < PIPE_LAT; i++) begin
            sq_side_reg[i] <= sq_side_reg[i-1];
        end
    end

    assign sq_o = sq_side_reg[PIPE_LAT-1];

    // M1: near-origin test and 32x32 partial products of the wide products
    always_ff @(posedge clk)
    begin
        tm1_reg.sign   <= sq_o.sign;
        tm1_reg.origin <= (sq_o.s == 64'd0) || (root < {16'd0, thr_reg});
        rm1_reg   <= root;
        axm1_reg  <= sq_o.ax;
        aym1_reg  <= sq_o.ay;
        sm1_reg   <= sq_o.s;
        pa_lo_reg <= sq_o.ay * sq_o.cmag[31:0];
        pa_hi_reg <= sq_o.ay * sq_o.cmag[63:32];
        pb_lo_reg <= sq_o.ax * sq_o.cmag[31:0];
        pb_hi_reg <= sq_o.ax * sq_o.cmag[63:32];
        ps_lo_reg <= sq_o.s[31:0] * root;
        ps_hi_reg <= sq_o.s[63:32] * root;
    end

    // M2: combine partials
    always_ff @(posedge clk)
    begin
        tm2_reg  <= tm1_reg;
        rm2_reg  <= rm1_reg;
        axm2_reg <= axm1_reg;
        aym2_reg <= aym1_reg;
        sm2_reg  <= sm1_reg;
        aycm_reg <= {pa_hi_reg, 32'd0} + {32'd0, pa_lo_reg};
        axcm_reg <= {pb_hi_reg, 32'd0} + {32'd0, pb_lo_reg};
        sr_reg   <= {ps_hi_reg, 32'd0} + {32'd0, ps_lo_reg};
    end

    rmj_div #(.NUM_W(N0_W), .DEN_W(32)) u_div_rx (
        .clk (clk), .num ({axm2_reg, {FRAC_BITS{1'b0}}}), .den (rm2_reg),
        .quo (q0), .ovf (o0)
    );
    rmj_div #(.NUM_W(N0_W), .DEN_W(32)) u_div_ry (
        .clk (clk), .num ({aym2_reg, {FRAC_BITS{1'b0}}}), .den (rm2_reg),
        .quo (q1), .ovf (o1)
    );
    rmj_div #(.NUM_W(N2_W), .DEN_W(64)) u_div_bx (
        .clk (clk), .num ({aym2_reg, {(2*FRAC_BITS){1'b0}}}), .den (sm2_reg),
        .quo (q2), .ovf (o2)
    );
    rmj_div #(.NUM_W(N2_W), .DEN_W(64)) u_div_by (
        .clk (clk), .num ({axm2_reg, {(2*FRAC_BITS){1'b0}}}), .den (sm2_reg),
        .quo (q3), .ovf (o3)
    );
    rmj_div #(.NUM_W(N4_W), .DEN_W(96)) u_div_cx (
        .clk (clk), .num ({aycm_reg[94:0], {FRAC_BITS{1'b0}}}), .den (sr_reg),
        .quo (q4), .ovf (o4)
    );
    rmj_div #(.NUM_W(N4_W), .DEN_W(96)) u_div_cy (
        .clk (clk), .num ({axcm_reg[94:0], {FRAC_BITS{1'b0}}}), .den (sr_reg),
        .quo (q5), .ovf (o5)
    );

    always_ff @(posedge clk)
    begin
        dv_tag_reg[0] <= tm2_reg;
        for (int i = 1; i < PIPE_LAT; i++) begin
            dv_tag_reg[i] <= dv_tag_reg[i-1];
        end
    end

    assign dv_o = dv_tag_reg[PIPE_LAT-1];

    // signs: bearing x is -y/s, rate terms carry the sign of c
    assign c0 = rmj_clamp(dv_o.sign.x_neg, q0, o0);
    assign c1 = rmj_clamp(dv_o.sign.y_neg, q1, o1);
    assign c2 = rmj_clamp(dv_o.sign.y_pos, q2, o2);
    assign c3 = rmj_clamp(dv_o.sign.x_neg, q3, o3);
    assign c4 = rmj_clamp(dv_o.sign.y_neg ^ dv_o.sign.c_neg, q4, o4);
    assign c5 = rmj_clamp(dv_o.sign.x_neg ^ !dv_o.sign.c_neg, q5, o5);

    always_comb
    begin
        jac_next = '0;
        if (dv_o.origin) begin
            jac_next.origin_flag = 1'b1;
        end else begin
            jac_next.d_range_d_x    = c0.val;
            jac_next.d_range_d_y    = c1.val;
            jac_next.d_bearing_d_x  = c2.val;
            jac_next.d_bearing_d_y  = c3.val;
            jac_next.d_rate_d_x     = c4.val;
            jac_next.d_rate_d_y     = c5.val;
            jac_next.saturated_flag = c0.sat | c1.sat | c2.sat | c3.sat | c4.sat | c5.sat;
        end
    end

    always_ff @(posedge clk)
    begin
        jac_reg <= jac_next;
    end

    assign done     = done_reg;
    assign jacobian = jac_reg;

    // every accepted transaction comes out after the fixed latency
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##TOTAL_LAT done)
        else $error("accepted track did not produce a result");

    // zeroed result near the origin
    a_origin_zero : assert property (@(posedge clk) disable iff (!rst_n)
        done && jacobian.origin_flag |->
            jacobian.d_range_d_x == 32'sd0 && jacobian.d_range_d_y == 32'sd0 &&
            jacobian.d_bearing_d_x == 32'sd0 && jacobian.d_bearing_d_y == 32'sd0 &&
            jacobian.d_rate_d_x == 32'sd0 && jacobian.d_rate_d_y == 32'sd0 &&
            !jacobian.saturated_flag)
        else $error("origin result not zeroed");

    // a saturation flag means at least one entry sits at a limit
    a_sat_limit : assert property (@(posedge clk) disable iff (!rst_n)
        done && jacobian.saturated_flag |->
            jacobian.d_range_d_x == 32'h7fff_ffff || jacobian.d_range_d_x == 32'h8000_0000 ||
            jacobian.d_range_d_y == 32'h7fff_ffff || jacobian.d_range_d_y == 32'h8000_0000 ||
            jacobian.d_bearing_d_x == 32'h7fff_ffff ||
            jacobian.d_bearing_d_x == 32'h8000_0000 ||
            jacobian.d_bearing_d_y == 32'h7fff_ffff ||
            jacobian.d_bearing_d_y == 32'h8000_0000 ||
            jacobian.d_rate_d_x == 32'h7fff_ffff || jacobian.d_rate_d_x == 32'h8000_0000 ||
            jacobian.d_rate_d_y == 32'h7fff_ffff || jacobian.d_rate_d_y == 32'h8000_0000)
        else $error("saturation flag without clamped entry");

endmodule

// File: dv/radar_measurement_jacobian_checker.sv
// Checker for the radar measurement Jacobian: predicts each track transaction and compares.
`timescale 1ns / 100ps

module radar_measurement_jacobian_checker
    import rmj_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  rmj_track_t  track,
    input  logic        done,
    input  rmj_jac_t    jacobian,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output int          fails,
    output int          pending
);

    localparam int FB = 16;

    rmj_jac_t    jac_expected_q[$];
    logic [15:0] thresh;

    function automatic logic [63:0] root_floor(input logic [63:0] s);
        logic [63:0] op;
        logic [63:0] res;
        logic [63:0] one;
        op  = s;
        res = 0;
        one = 64'd1 << 62;
        while (one > op)
            one = one >> 2;
        while (one != 0)
        begin
            if (op >= res + one)
            begin
                op  = op - (res + one);
                res = (res >> 1) + one;
            end
            else
                res = res >> 1;
            one = one >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] sat_q(input logic neg, input logic [127:0] q,
                                          inout logic sat);
        logic [127:0] lim;
        logic [31:0]  mag;
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        if (q > lim)
        begin
            mag = lim[31:0];
            sat = 1'b1;
        end
        else
            mag = q[31:0];
        return neg ? (32'd0 - mag) : mag;
    endfunction

    function automatic rmj_jac_t linearize(input rmj_track_t t, input logic [15:0] thr);
        rmj_jac_t           j;
        logic [31:0]        ax;
        logic [31:0]        ay;
        logic [63:0]        s;
        logic [63:0]        r;
        logic signed [65:0] p1;
        logic signed [65:0] p2;
        logic signed [65:0] c;
        logic               cneg;
        logic [63:0]        cmag;
        logic               sat;
        logic [127:0]       num;
        j   = '0;
        sat = 1'b0;
        ax  = t.pos_x[31] ? 32'd0 - t.pos_x : t.pos_x;
        ay  = t.pos_y[31] ? 32'd0 - t.pos_y : t.pos_y;
        s   = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay);
        r   = root_floor(s);
        if (s == 0 || r < 64'(thr))
        begin
            j.origin_flag = 1'b1;
            return j;
        end
        p1   = 66'(t.vel_x) * 66'(t.pos_y);
        p2   = 66'(t.vel_y) * 66'(t.pos_x);
        c    = p1 - p2;
        cneg = c < 0;
        cmag = cneg ? 64'(-c) : 64'(c);
        num  = 128'(ax) << FB;
        j.d_range_d_x = sat_q(t.pos_x[31], num / 128'(r), sat);
        num  = 128'(ay) << FB;
        j.d_range_d_y = sat_q(t.pos_y[31], num / 128'(r), sat);
        num  = 128'(ay) << (2 * FB);
        j.d_bearing_d_x = sat_q(!t.pos_y[31] && t.pos_y != 0, num / 128'(s), sat);
        num  = 128'(ax) << (2 * FB);
        j.d_bearing_d_y = sat_q(t.pos_x[31], num / 128'(s), sat);
        num  = (128'(ay) * 128'(cmag)) << FB;
        j.d_rate_d_x = sat_q(t.pos_y[31] != cneg, (num / 128'(s)) / 128'(r), sat);
        num  = (128'(ax) * 128'(cmag)) << FB;
        j.d_rate_d_y = sat_q(t.pos_x[31] != !cneg, (num / 128'(s)) / 128'(r), sat);
        j.saturated_flag = sat;
        return j;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rmj_jac_t want;
        if (!rst_n)
        begin
            thresh  = THRESH_RESET;
            fails   <= 0;
            pending <= 0;
            jac_expected_q.delete();
        end
        else
        begin
            if (start && !busy)
                jac_expected_q.push_back(linearize(track, thresh));
            if (done)
            begin
                if (jac_expected_q.size() == 0)
                begin
                    $display("%t: unexpected result %h", $time, jacobian);
                    fails <= fails + 1;
                end
                else
                begin
                    want = jac_expected_q.pop_front();
                    if (want !== jacobian)
                    begin
                        $display("%t: mismatch expected %h actual %h", $time, want, jacobian);
                        fails <= fails + 1;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                thresh = cfg_data;
            pending <= jac_expected_q.size();
        end
    end

endmodule

// File: dv/radar_measurement_jacobian_test.sv
// Testbench top for the radar measurement Jacobian: stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module radar_measurement_jacobian_test;
    import rmj_pkg::*;

    localparam int LAT_WAIT = 48;     // pipeline is 40 deep, plus margin
    localparam int WD_LIMIT = 2000;   // idle cycles before the watchdog fires
    localparam int N_RAND   = 600;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    rmj_track_t  track;
    logic        done;
    rmj_jac_t    jacobian;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    int          fails;
    int          pending;
    int          idle_cycles = 0;
    bit          no_gaps;   // burst mode: back-to-back transactions

    radar_measurement_jacobian uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .track     (track),
        .done      (done),
        .jacobian  (jacobian),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    radar_measurement_jacobian_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .track     (track),
        .done      (done),
        .jacobian  (jacobian),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .fails     (fails),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Watchdog: any accepted transaction on any channel resets the count.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Drive one track transaction; start stays high across back-to-back items.
    task automatic send_track(input rmj_track_t t);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        track <= t;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Let the pipeline empty completely: also serves as the sender pause.
    task automatic drain;
        start <= 1'b0;
        repeat (LAT_WAIT) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LAT_WAIT) @(posedge clk);
    endtask

    // Threshold write, only ever issued with the block idle.
    task automatic write_thresh(input logic [15:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mix of magnitudes so ranges land near the threshold and near overflow.
    function automatic logic [31:0] rand_coord;
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $urandom_range(0, 64);
            2: v = 32'd0 - 32'($urandom_range(0, 64));
            3: v = $signed($urandom) >>> $urandom_range(0, 31);
            4: v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: v = $signed($urandom) >>> 16;
        endcase
        return v;
    endfunction

    function automatic rmj_track_t rand_track;
        rmj_track_t t;
        t.pos_x = rand_coord();
        t.pos_y = rand_coord();
        t.vel_x = rand_coord();
        t.vel_y = rand_coord();
        return t;
    endfunction

    function automatic rmj_track_t mk(input logic [31:0] px, input logic [31:0] py,
                                      input logic [31:0] vx, input logic [31:0] vy);
        rmj_track_t t;
        t.pos_x = px;
        t.pos_y = py;
        t.vel_x = vx;
        t.vel_y = vy;
        return t;
    endfunction

    task automatic directed;
        send_track(mk(0, 0, 32'h0001_0000, 32'h0001_0000));             // zero range
        send_track(mk(1, 0, 5, 7));                                     // one lsb range
        send_track(mk(0, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000));
        send_track(mk(3, 4, 32'h8000_0000, 32'h7fff_ffff));
        send_track(mk(6, 0, 1, 1));                                     // just under reset thr
        send_track(mk(7, 0, 1, 1));                                     // at reset thr
        send_track(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_track(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        send_track(mk(32'h8000_0000, 0, 0, 32'h7fff_ffff));
        send_track(mk(0, 32'h7fff_ffff, 32'h8000_0000, 0));
        send_track(mk(32'h0001_0000, 0, 0, 32'h0001_0000));             // unit x, tangential v
        send_track(mk(0, 32'hffff_0000, 32'h0001_0000, 0));
        send_track(mk(32'h0003_0000, 32'h0004_0000, 32'hfffe_0000, 32'h0005_0000));
        send_track(mk(32'h0000_ffff, 32'hffff_0001, 32'h1234_5678, 32'hedcb_a987));
        send_track(mk(65535, 0, 0, 0));
        send_track(mk(65534, 1, 32'h7fff_ffff, 32'h8000_0000));
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        track       = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        no_gaps     = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed();                  // reset threshold
        write_thresh(16'd0);
        directed();
        write_thresh(16'hffff);
        directed();
        write_thresh(16'd7);

        // Random phases; threshold changes between them, bursts alternate with gaps.
        for (int ph = 0; ph < 6; ph++)
        begin
            no_gaps = ph[0];
            for (int i = 0; i < N_RAND / 6; i++)
                send_track(rand_track());
            case (ph)
                0: write_thresh(16'd0);
                1: write_thresh(16'hffff);
                2: write_thresh(16'($urandom));
                3: write_thresh(16'($urandom_range(0, 64)));
                default: write_thresh(THRESH_RESET);
            endcase
        end

        drain();
        if (fails == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
sv/rmj_pkg.sv
sv/rmj_sqrt.sv
sv/rmj_div.sv
sv/radar_measurement_jacobian.sv
dv/radar_measurement_jacobian_checker.sv
dv/radar_measurement_jacobian_test.sv
